// ===== rtl/csvt_pkg.sv =====
package csvt_pkg;

    localparam int MAX_FIELDS = 64;
    // Field indices stop at the top of the six-bit field, or earlier for small limits.
    localparam logic [5:0] FIELD_TOP = (MAX_FIELDS > 64) ? 6'd63 : 6'(MAX_FIELDS - 1);

    localparam int MAX_RESULTS = 4;
    localparam int RES_IW = $clog2(MAX_RESULTS);
    localparam int RES_CW = RES_IW + 1;

    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_EOF  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        KIND_DATA       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2,
        KIND_EMPTY_FILE = 2'd3
    } kind_t;

    typedef enum logic [1:0]
    {
        BOM_START     = 2'd0,
        BOM_SEEN_EF   = 2'd1,
        BOM_SEEN_EFBB = 2'd2,
        BOM_DONE      = 2'd3
    } bom_t;

    typedef struct packed
    {
        op_t        opcode;
        logic [7:0] byte_in;
    } in_t;

    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] value;
        logic [5:0] field_index;
        logic       is_header;
        logic       beyond_header;
        logic       last;
    } res_t;

    typedef struct packed
    {
        bom_t       bom_phase;
        logic       held_cr;
        logic       quoting;
        logic       quote_pending;
        logic       line_has_bytes;
        logic       on_header_line;
        logic       seen_any_byte;
        logic [5:0] current_field;
        logic [6:0] header_field_count;
        logic       field_overflow;
    } st_t;

    typedef struct packed
    {
        res_t [MAX_RESULTS-1:0] res;
        logic [RES_CW-1:0]      cnt;
    } bundle_t;

    localparam st_t ST_RESET = '{
        bom_phase:          BOM_START,
        held_cr:            1'b0,
        quoting:            1'b0,
        quote_pending:      1'b0,
        line_has_bytes:     1'b0,
        on_header_line:     1'b1,
        seen_any_byte:      1'b0,
        current_field:      6'd0,
        header_field_count: 7'd0,
        field_overflow:     1'b0
    };

endpackage

// ===== rtl/csvt_step.sv =====
module csvt_step
(
    input  csvt_pkg::st_t     st,
    input  csvt_pkg::in_t     item,
    output csvt_pkg::st_t     st_next,
    output csvt_pkg::bundle_t bundle
);

    function automatic void emit
    (
        input    csvt_pkg::kind_t   k,
        input    logic [7:0]        v,
        input    csvt_pkg::st_t     s,
        inout    csvt_pkg::bundle_t b
    );
        csvt_pkg::res_t r;
        logic           not_err;
        not_err         = (k != csvt_pkg::KIND_EMPTY_FILE);
        r.kind          = k;
        r.value         = (k == csvt_pkg::KIND_DATA) ? v : 8'd0;
        r.field_index   = not_err ? s.current_field : 6'd0;
        r.is_header     = not_err && s.on_header_line;
        r.beyond_header = not_err && !s.on_header_line &&
                          (s.field_overflow ||
                           ({1'b0, s.current_field} >= s.header_field_count));
        r.last          = 1'b0;
        if (b.cnt < csvt_pkg::RES_CW'(csvt_pkg::MAX_RESULTS))
        begin
            b.res[b.cnt[csvt_pkg::RES_IW-1:0]] = r;
            b.cnt = b.cnt + csvt_pkg::RES_CW'(1);
        end
    endfunction

    function automatic void clear_line(inout csvt_pkg::st_t s);
        s.quoting        = 1'b0;
        s.quote_pending  = 1'b0;
        s.line_has_bytes = 1'b0;
        s.current_field  = 6'd0;
        s.field_overflow = 1'b0;
        s.on_header_line = 1'b0;
    endfunction

    function automatic void end_line
    (
        inout csvt_pkg::st_t     s,
        inout csvt_pkg::bundle_t b
    );
        if (s.on_header_line || s.line_has_bytes)
        begin
            emit(csvt_pkg::KIND_RECORD_END, 8'd0, s, b);
            if (s.on_header_line)
            begin
                s.header_field_count = {1'b0, s.current_field} + 7'd1;
            end
        end
        clear_line(s);
    endfunction

    function automatic void content_byte
    (
        input logic [7:0]        c,
        inout csvt_pkg::st_t     s,
        inout csvt_pkg::bundle_t b
    );
        logic handled;
        handled          = 1'b0;
        s.line_has_bytes = 1'b1;
        if (s.quote_pending)
        begin
            s.quote_pending = 1'b0;
            if (c == csvt_pkg::CH_QUOTE)
            begin
                // A doubled quote inside a quoted field stands for one literal quote.
                emit(csvt_pkg::KIND_DATA, c, s, b);
                handled = 1'b1;
            end
            else
            begin
                s.quoting = 1'b0;
            end
        end
        if (!handled)
        begin
            if (s.quoting)
            begin
                if (c == csvt_pkg::CH_QUOTE)
                begin
                    s.quote_pending = 1'b1;
                end
                else
                begin
                    emit(csvt_pkg::KIND_DATA, c, s, b);
                end
            end
            else if (c == csvt_pkg::CH_QUOTE)
            begin
                s.quoting = 1'b1;
            end
            else if (c == csvt_pkg::CH_COMMA)
            begin
                emit(csvt_pkg::KIND_FIELD_END, 8'd0, s, b);
                if (s.current_field < csvt_pkg::FIELD_TOP)
                begin
                    s.current_field = s.current_field + 6'd1;
                end
                else
                begin
                    s.field_overflow = 1'b1;
                end
            end
            else
            begin
                emit(csvt_pkg::KIND_DATA, c, s, b);
            end
        end
    endfunction

    function automatic void stream_byte
    (
        input logic [7:0]        c,
        inout csvt_pkg::st_t     s,
        inout csvt_pkg::bundle_t b
    );
        logic done;
        done            = 1'b0;
        s.seen_any_byte = 1'b1;
        if (s.held_cr)
        begin
            s.held_cr = 1'b0;
            if (c == csvt_pkg::CH_LF)
            begin
                end_line(s, b);
                done = 1'b1;
            end
            else
            begin
                // The held carriage return was not part of a line break, so it is data.
                content_byte(csvt_pkg::CH_CR, s, b);
            end
        end
        if (!done)
        begin
            if (c == csvt_pkg::CH_CR)
            begin
                s.held_cr = 1'b1;
            end
            else if (c == csvt_pkg::CH_LF)
            begin
                end_line(s, b);
            end
            else
            begin
                content_byte(c, s, b);
            end
        end
    endfunction

    always_comb
    begin
        csvt_pkg::st_t         s;
        csvt_pkg::bundle_t     b;
        logic [csvt_pkg::RES_CW-1:0] last_pos;
        s = st;
        b = '0;
        if (item.opcode == csvt_pkg::OP_BYTE)
        begin
            unique case (s.bom_phase)
                csvt_pkg::BOM_START:
                begin
                    if (item.byte_in == csvt_pkg::BOM_BYTE0)
                    begin
                        s.bom_phase = csvt_pkg::BOM_SEEN_EF;
                    end
                    else
                    begin
                        s.bom_phase = csvt_pkg::BOM_DONE;
                        stream_byte(item.byte_in, s, b);
                    end
                end
                csvt_pkg::BOM_SEEN_EF:
                begin
                    if (item.byte_in == csvt_pkg::BOM_BYTE1)
                    begin
                        s.bom_phase = csvt_pkg::BOM_SEEN_EFBB;
                    end
                    else
                    begin
                        s.bom_phase = csvt_pkg::BOM_DONE;
                        stream_byte(csvt_pkg::BOM_BYTE0, s, b);
                        stream_byte(item.byte_in, s, b);
                    end
                end
                csvt_pkg::BOM_SEEN_EFBB:
                begin
                    s.bom_phase = csvt_pkg::BOM_DONE;
                    if (item.byte_in != csvt_pkg::BOM_BYTE2)
                    begin
                        stream_byte(csvt_pkg::BOM_BYTE0, s, b);
                        stream_byte(csvt_pkg::BOM_BYTE1, s, b);
                        stream_byte(item.byte_in, s, b);
                    end
                end
                csvt_pkg::BOM_DONE:
                begin
                    stream_byte(item.byte_in, s, b);
                end
            endcase
        end
        else
        begin
            // A partial byte-order mark left at end of file is replayed as data.
            if (s.bom_phase == csvt_pkg::BOM_SEEN_EF)
            begin
                stream_byte(csvt_pkg::BOM_BYTE0, s, b);
            end
            else if (s.bom_phase == csvt_pkg::BOM_SEEN_EFBB)
            begin
                stream_byte(csvt_pkg::BOM_BYTE0, s, b);
                stream_byte(csvt_pkg::BOM_BYTE1, s, b);
            end
            s.held_cr = 1'b0;
            if (s.on_header_line && !s.seen_any_byte)
            begin
                emit(csvt_pkg::KIND_EMPTY_FILE, 8'd0, s, b);
            end
            else if (s.on_header_line || s.line_has_bytes)
            begin
                emit(csvt_pkg::KIND_RECORD_END, 8'd0, s, b);
            end
            s = csvt_pkg::ST_RESET;
        end
        last_pos = b.cnt - csvt_pkg::RES_CW'(1);
        if (b.cnt != '0)
        begin
            b.res[last_pos[csvt_pkg::RES_IW-1:0]].last = 1'b1;
        end
        st_next = s;
        bundle  = b;
    end

endmodule

// ===== rtl/csvt_out_buf.sv =====
module csvt_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  csvt_pkg::bundle_t bundle,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output csvt_pkg::res_t    out_data
);

    csvt_pkg::res_t [csvt_pkg::MAX_RESULTS-1:0] res_reg;
    logic [csvt_pkg::RES_CW-1:0]                cnt_reg;
    logic [csvt_pkg::RES_IW-1:0]                pos_reg;
    logic                                       pop;
    logic                                       done;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = res_reg[pos_reg];
    assign pop       = out_valid && !out_stall;
    assign done      = pop && (({1'b0, pos_reg} + csvt_pkg::RES_CW'(1)) == cnt_reg);
    // The buffer can take a new group of results in the cycle its last one leaves.
    assign free      = !out_valid || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= bundle.cnt;
            pos_reg <= '0;
        end
        else if (done)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else if (pop)
        begin
            pos_reg <= pos_reg + csvt_pkg::RES_IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= bundle.res;
        end
    end

endmodule

// ===== rtl/csv_record_tokenizer.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_stall     | in_data  (opcode, byte_in)
// out     | output    | out_valid / out_stall   | out_data (kind, value, field_index,
//         |           |                         |           is_header, beyond_header, last)
// An accepted item is held in the input register; the step logic then updates the state
// and, once the output buffer is free, loads its zero to four results into the buffer.
// The buffer sends one result per cycle while out_stall is low, and a following item
// with results waits in the input register until the buffer is free; items with no
// result pass at one per cycle. Reset returns all state to the start of a file;
// in_stall rises only in such a wait.
module csv_record_tokenizer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  csvt_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output csvt_pkg::res_t out_data
);

    logic              in_valid_reg;
    csvt_pkg::in_t     in_data_reg;
    csvt_pkg::st_t     st_reg;
    csvt_pkg::st_t     st_next;
    csvt_pkg::bundle_t step_bundle;
    logic              buf_free;
    logic              commit;
    logic              load;

    csvt_step u_step
    (
        .st      (st_reg),
        .item    (in_data_reg),
        .st_next (st_next),
        .bundle  (step_bundle)
    );

    csvt_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .bundle    (step_bundle),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // An item that yields no result commits even while the output buffer is busy.
    assign commit   = in_valid_reg && ((step_bundle.cnt == '0) || buf_free);
    assign load     = commit && (step_bundle.cnt != '0);
    assign in_stall = in_valid_reg && !commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= csvt_pkg::ST_RESET;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                in_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/csvt_checker.sv =====
module csvt_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input csvt_pkg::res_t out_data
);

    // A stalled result stays in place until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // The input side only waits when a result is waiting on the output side.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // Nothing is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!out_valid && !in_stall))
        else $error("activity during reset");

    // An empty-file error is the final result of its item, with zero index, flags and value.
    a_empty_file: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.kind == csvt_pkg::KIND_EMPTY_FILE)) |->
        (out_data.last && (out_data.field_index == 6'd0) && !out_data.is_header
         && !out_data.beyond_header && (out_data.value == 8'd0)))
        else $error("malformed empty-file result");

endmodule

bind csv_record_tokenizer csvt_checker u_checker (.*);

// ===== dv/csv_token_sb_pkg.sv =====
package csv_token_sb_pkg;

    class token_scoreboard;
        csvt_pkg::res_t expected_tokens[$];
        int             mismatch_count;
        int             checked_count;

        // Tokenizer state, kept in step with every accepted input.
        csvt_pkg::bom_t mark_phase;
        bit             cr_held;
        bit             quoted;
        bit             quote_waiting;
        bit             line_started;
        bit             hdr_line;
        bit             file_started;
        bit             index_overflow;
        logic [5:0]     field_no;
        logic [6:0]     header_width;
        csvt_pkg::res_t burst[$];

        function new();
            mismatch_count = 0;
            checked_count  = 0;
            restart_file();
        endfunction

        function void restart_file();
            mark_phase     = csvt_pkg::BOM_START;
            cr_held        = 1'b0;
            quoted         = 1'b0;
            quote_waiting  = 1'b0;
            line_started   = 1'b0;
            hdr_line       = 1'b1;
            file_started   = 1'b0;
            index_overflow = 1'b0;
            field_no       = 6'd0;
            header_width   = 7'd0;
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function void add_token(csvt_pkg::kind_t kind, logic [7:0] value);
            csvt_pkg::res_t tok;
            if (burst.size() >= csvt_pkg::MAX_RESULTS)
                return;
            tok.kind          = kind;
            tok.value         = (kind == csvt_pkg::KIND_DATA) ? value : 8'd0;
            tok.field_index   = (kind == csvt_pkg::KIND_EMPTY_FILE) ? 6'd0 : field_no;
            tok.is_header     = (kind != csvt_pkg::KIND_EMPTY_FILE) && hdr_line;
            tok.beyond_header = (kind != csvt_pkg::KIND_EMPTY_FILE) && !hdr_line &&
                                (index_overflow || {1'b0, field_no} >= header_width);
            tok.last          = 1'b0;
            burst.insert(burst.size(), tok);
        endfunction

        function void close_line();
            if (hdr_line || line_started)
            begin
                add_token(csvt_pkg::KIND_RECORD_END, 8'd0);
                if (hdr_line)
                    header_width = {1'b0, field_no} + 7'd1;
            end
            quoted         = 1'b0;
            quote_waiting  = 1'b0;
            line_started   = 1'b0;
            field_no       = 6'd0;
            index_overflow = 1'b0;
            hdr_line       = 1'b0;
        endfunction

        function void take_content(logic [7:0] c);
            line_started = 1'b1;
            // A quote inside quotes is held until the next byte shows whether it was doubled.
            if (quote_waiting)
            begin
                quote_waiting = 1'b0;
                if (c == csvt_pkg::CH_QUOTE)
                begin
                    add_token(csvt_pkg::KIND_DATA, c);
                    return;
                end
                quoted = 1'b0;
            end
            if (quoted)
            begin
                if (c == csvt_pkg::CH_QUOTE)
                    quote_waiting = 1'b1;
                else
                    add_token(csvt_pkg::KIND_DATA, c);
                return;
            end
            if (c == csvt_pkg::CH_QUOTE)
                quoted = 1'b1;
            else if (c == csvt_pkg::CH_COMMA)
            begin
                add_token(csvt_pkg::KIND_FIELD_END, 8'd0);
                if (field_no < csvt_pkg::FIELD_TOP)
                    field_no++;
                else
                    index_overflow = 1'b1;
            end
            else
                add_token(csvt_pkg::KIND_DATA, c);
        endfunction

        function void take_byte(logic [7:0] b);
            file_started = 1'b1;
            if (cr_held)
            begin
                cr_held = 1'b0;
                if (b == csvt_pkg::CH_LF)
                begin
                    close_line();
                    return;
                end
                take_content(csvt_pkg::CH_CR);
            end
            if (b == csvt_pkg::CH_CR)
                cr_held = 1'b1;
            else if (b == csvt_pkg::CH_LF)
                close_line();
            else
                take_content(b);
        endfunction

        function void predict_tokens(csvt_pkg::in_t item);
            burst.delete();
            if (item.opcode == csvt_pkg::OP_BYTE)
            begin
                case (mark_phase)
                    csvt_pkg::BOM_START:
                        if (item.byte_in == csvt_pkg::BOM_BYTE0)
                            mark_phase = csvt_pkg::BOM_SEEN_EF;
                        else
                        begin
                            mark_phase = csvt_pkg::BOM_DONE;
                            take_byte(item.byte_in);
                        end
                    csvt_pkg::BOM_SEEN_EF:
                        if (item.byte_in == csvt_pkg::BOM_BYTE1)
                            mark_phase = csvt_pkg::BOM_SEEN_EFBB;
                        else
                        begin
                            mark_phase = csvt_pkg::BOM_DONE;
                            take_byte(csvt_pkg::BOM_BYTE0);
                            take_byte(item.byte_in);
                        end
                    csvt_pkg::BOM_SEEN_EFBB:
                    begin
                        mark_phase = csvt_pkg::BOM_DONE;
                        if (item.byte_in != csvt_pkg::BOM_BYTE2)
                        begin
                            take_byte(csvt_pkg::BOM_BYTE0);
                            take_byte(csvt_pkg::BOM_BYTE1);
                            take_byte(item.byte_in);
                        end
                    end
                    default:
                        take_byte(item.byte_in);
                endcase
            end
            else
            begin
                // A partial mark at end of file is replayed as data first.
                if (mark_phase == csvt_pkg::BOM_SEEN_EF)
                    take_byte(csvt_pkg::BOM_BYTE0);
                else if (mark_phase == csvt_pkg::BOM_SEEN_EFBB)
                begin
                    take_byte(csvt_pkg::BOM_BYTE0);
                    take_byte(csvt_pkg::BOM_BYTE1);
                end
                cr_held = 1'b0;
                if (hdr_line && !file_started)
                    add_token(csvt_pkg::KIND_EMPTY_FILE, 8'd0);
                else if (hdr_line || line_started)
                    add_token(csvt_pkg::KIND_RECORD_END, 8'd0);
                restart_file();
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                expected_tokens.insert(expected_tokens.size(), burst[i]);
        endfunction

        task check_result(csvt_pkg::res_t got);
            csvt_pkg::res_t want;
            checked_count++;
            if (expected_tokens.size() == 0)
            begin
                report_mismatch($sformatf("token %0d of kind %0d arrived unexpectedly",
                                          checked_count, got.kind));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind != want.kind)
                report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                          checked_count, got.kind, want.kind));
            if (got.value != want.value)
                report_mismatch($sformatf("token %0d value %02h, expected %02h",
                                          checked_count, got.value, want.value));
            if (got.field_index != want.field_index)
                report_mismatch($sformatf("token %0d field_index %0d, expected %0d",
                                          checked_count, got.field_index, want.field_index));
            if (got.is_header != want.is_header)
                report_mismatch($sformatf("token %0d is_header %0b, expected %0b",
                                          checked_count, got.is_header, want.is_header));
            if (got.beyond_header != want.beyond_header)
                report_mismatch($sformatf("token %0d beyond_header %0b, expected %0b",
                                          checked_count, got.beyond_header,
                                          want.beyond_header));
            if (got.last != want.last)
                report_mismatch($sformatf("token %0d last %0b, expected %0b",
                                          checked_count, got.last, want.last));
        endtask
    endclass

endpackage

// ===== dv/tb_csv_record_tokenizer.sv =====
module tb_csv_record_tokenizer;

    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 150;
    localparam int LIMIT_TIME   = 5_000_000;
    localparam int EOF_MARK     = -1;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    csvt_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    csvt_pkg::res_t out_data;

    csv_token_sb_pkg::token_scoreboard sb = new();

    csvt_pkg::in_t file_q[$];
    bit  sender_eager  = 1'b0;
    bit  sink_eager    = 1'b0;
    bit  hurry         = 1'b0;
    bit  hold_request  = 1'b0;
    bit  result_taken  = 1'b0;

    csv_record_tokenizer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_wait(inout bit eager);
        // Runs of back-to-back transfers alternate with runs of random waits.
        if ($urandom_range(0, 31) == 0)
            eager = !eager;
        if (eager)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 3);
    endfunction

    function automatic csvt_pkg::in_t byte_item(logic [7:0] b);
        return '{opcode: csvt_pkg::OP_BYTE, byte_in: b};
    endfunction

    function automatic csvt_pkg::in_t eof_item();
        return '{opcode: csvt_pkg::OP_EOF, byte_in: 8'($urandom)};
    endfunction

    task automatic add_byte(logic [7:0] b);
        file_q.insert(file_q.size(), byte_item(b));
    endtask

    task automatic add_record(int fields, bit wide, bit final_line);
        int         len;
        bit         quoted;
        logic [7:0] c;
        for (int f = 0; f < fields; f++)
        begin
            if (f > 0)
                add_byte(csvt_pkg::CH_COMMA);
            len    = wide ? $urandom_range(0, 1) : $urandom_range(0, 4);
            quoted = ($urandom_range(0, 2) == 0);
            if (quoted)
                add_byte(csvt_pkg::CH_QUOTE);
            for (int i = 0; i < len; i++)
            begin
                if (quoted && $urandom_range(0, 4) == 0)
                begin
                    // Inside quotes a doubled quote, a comma or a lone carriage return is data.
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            add_byte(csvt_pkg::CH_QUOTE);
                            add_byte(csvt_pkg::CH_QUOTE);
                        end
                        1:       add_byte(csvt_pkg::CH_COMMA);
                        default: add_byte(csvt_pkg::CH_CR);
                    endcase
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    c = 8'($urandom);
                    if (c == csvt_pkg::CH_QUOTE || c == csvt_pkg::CH_COMMA ||
                        c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF)
                        c ^= 8'h40;
                    add_byte(c);
                end
                else
                    add_byte(8'($urandom_range(8'h30, 8'h7A)));
            end
            // Now and then a quote is left open up to the end of the line.
            if (quoted && $urandom_range(0, 15) != 0)
                add_byte(csvt_pkg::CH_QUOTE);
        end
        case ($urandom_range(0, final_line ? 3 : 1))
            0: add_byte(csvt_pkg::CH_LF);
            1:
            begin
                add_byte(csvt_pkg::CH_CR);
                add_byte(csvt_pkg::CH_LF);
            end
            2: add_byte(csvt_pkg::CH_CR);
            default: ;
        endcase
    endtask

    task automatic build_csv_file(bit well_formed);
        int header_fields;
        int lines;
        int n;
        bit wide;
        file_q.delete();
        if (!well_formed)
        begin
            repeat ($urandom_range(0, 24))
            begin
                case ($urandom_range(0, 7))
                    0:       add_byte(csvt_pkg::CH_QUOTE);
                    1:       add_byte(csvt_pkg::CH_COMMA);
                    2:       add_byte(csvt_pkg::CH_CR);
                    3:       add_byte(csvt_pkg::CH_LF);
                    4:       add_byte(csvt_pkg::BOM_BYTE0);
                    5:       add_byte(csvt_pkg::BOM_BYTE1);
                    6:       add_byte(csvt_pkg::BOM_BYTE2);
                    default: add_byte(8'($urandom));
                endcase
            end
            file_q.insert(file_q.size(), eof_item());
            return;
        end
        case ($urandom_range(0, 5))
            0:
            begin
                add_byte(csvt_pkg::BOM_BYTE0);
                add_byte(csvt_pkg::BOM_BYTE1);
                add_byte(csvt_pkg::BOM_BYTE2);
            end
            1: add_byte(csvt_pkg::BOM_BYTE0);
            2:
            begin
                add_byte(csvt_pkg::BOM_BYTE0);
                add_byte(csvt_pkg::BOM_BYTE1);
            end
            default: ;
        endcase
        // A wide file can push the field index past its saturation point.
        wide          = ($urandom_range(0, 11) == 0);
        header_fields = wide ? $urandom_range(60, 70) : $urandom_range(1, 5);
        lines         = wide ? $urandom_range(0, 1) : $urandom_range(0, 4);
        add_record(header_fields, wide, lines == 0);
        for (int l = 1; l <= lines; l++)
        begin
            if (!wide && $urandom_range(0, 7) == 0)
                add_byte(csvt_pkg::CH_LF);
            else
            begin
                n = wide ? $urandom_range(60, 70)
                         : header_fields + int'($urandom_range(0, 4)) - 2;
                if (n < 1)
                    n = 1;
                add_record(n, wide, l == lines);
            end
        end
        file_q.insert(file_q.size(), eof_item());
    endtask

    task automatic send_item(csvt_pkg::in_t item);
        int gap;
        gap = hurry ? 0 : draw_wait(sender_eager);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= '{opcode: csvt_pkg::op_t'($urandom_range(0, 1)),
                          byte_in: 8'($urandom)};
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        sb.predict_tokens(item);
    endtask

    task automatic wait_for_results();
        // The offer is withdrawn first so that the last item is not transferred twice.
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result(out_data);
                result_taken = 1'b1;
            end
        end
    end

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            // Draw a fresh stall after every output transfer.
            if (result_taken)
            begin
                result_taken = 1'b0;
                stall_left   = draw_wait(sink_eager);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int directed_stream[$];
        int random_items;
        int files_sent;
        directed_stream = {EOF_MARK,
                           csvt_pkg::BOM_BYTE0, csvt_pkg::BOM_BYTE1, csvt_pkg::BOM_BYTE2,
                           EOF_MARK,
                           csvt_pkg::BOM_BYTE0, EOF_MARK,
                           csvt_pkg::CH_LF, EOF_MARK,
                           csvt_pkg::BOM_BYTE0, csvt_pkg::BOM_BYTE1, csvt_pkg::CH_COMMA,
                           csvt_pkg::CH_QUOTE, csvt_pkg::CH_QUOTE, csvt_pkg::CH_QUOTE,
                           csvt_pkg::CH_CR, csvt_pkg::CH_LF, csvt_pkg::CH_LF,
                           csvt_pkg::CH_QUOTE, 8'h00, csvt_pkg::CH_CR, 8'hFF,
                           csvt_pkg::CH_LF, csvt_pkg::CH_COMMA, csvt_pkg::CH_COMMA,
                           csvt_pkg::CH_CR, EOF_MARK};
        random_items = 0;
        files_sent   = 0;
        in_valid     = 1'b0;
        in_data      = byte_item(8'h00);
        rst_n        = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_stream[i])
            send_item(directed_stream[i] == EOF_MARK ? eof_item()
                                                     : byte_item(directed_stream[i][7:0]));

        while (random_items < RANDOM_ITEMS || files_sent < 6)
        begin
            if (files_sent == 2)
            begin
                // The output is held off while input keeps coming, so the block backs up.
                do
                begin
                    build_csv_file(1'b1);
                end
                while (file_q.size() < 20);
                hold_request = 1'b1;
                hurry        = 1'b1;
            end
            else
                build_csv_file($urandom_range(0, 5) != 0);
            if (files_sent == 5 || $urandom_range(0, 9) == 0)
                wait_for_results();
            foreach (file_q[i])
                send_item(file_q[i]);
            random_items += file_q.size();
            hurry = 1'b0;
            files_sent++;
        end

        wait_for_results();
        repeat (16) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #LIMIT_TIME;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
